[rtl/core/emwgs_pkg.sv]
// Shared constants and types for the reflective slip wall ghost state unit.
// No dependencies; imported by the top level.
package emwgs_pkg;

  typedef logic [30:0]        q31_t;   // unsigned Q15.16 quantity
  typedef logic signed [31:0] q32s_t;  // signed Q16.16 quantity

  localparam q31_t        SAT31       = 31'h7FFF_FFFF;
  localparam logic [18:0] GAMMA_RESET = 19'd91750;
  localparam logic [18:0] Q_ONE       = 19'd65536;

  // Register index decoded from the byte address.
  localparam logic REG_GAMMA = 1'b0;

endpackage

[rtl/core/emwgs_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// No dependencies; used by the top level for the normal length and the sound speed.
module emwgs_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   din,
  output logic [W/2-1:0] root
);

  localparam int R = W / 2;

  logic [W-1:0] x_s [1:R-1];
  logic [R-1:0] r_s [1:R-1];
  logic [R-1:0] q_s [1:R];

  genvar k;
  generate
    for (k = 0; k < R; k++) begin : g_step
      logic [W-1:0] xin;
      logic [R-1:0] rin;
      logic [R-1:0] qin;
      logic [R+1:0] rt;
      logic [R+1:0] tr;
      logic         ge;

      if (k == 0) begin : g_first
        assign xin = din;
        assign rin = '0;
        assign qin = '0;
      end else begin : g_rest
        assign xin = x_s[k];
        assign rin = r_s[k];
        assign qin = q_s[k];
      end

      assign rt = {rin, xin[W-1:W-2]};
      assign tr = {qin, 2'b01};
      assign ge = (rt >= tr);

      always_ff @(posedge clk) begin
        if (en) begin
          q_s[k+1] <= {qin[R-2:0], ge};
        end
      end

      if (k < R - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            x_s[k+1] <= xin << 2;
            r_s[k+1] <= ge ? R'(rt - tr) : R'(rt);
          end
        end
      end
    end
  endgenerate

  assign root = q_s[R];

endmodule

[rtl/core/emwgs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies; the dividend must be below the divisor times two to the QB.
module emwgs_div #(
  parameter int NW = 62,
  parameter int DW = 31,
  parameter int QB = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DW-1:0] rem_s [1:QB-1];
  logic [QB-1:0] lo_s  [1:QB-1];
  logic [DW-1:0] den_s [1:QB-1];
  logic [QB-1:0] quo_s [1:QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_step
      logic [DW-1:0] rin;
      logic [QB-1:0] lin;
      logic [DW-1:0] dv;
      logic [QB-1:0] qin;
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign rin = DW'(num[NW-1:QB]);
        assign lin = num[QB-1:0];
        assign dv  = den;
        assign qin = '0;
      end else begin : g_rest
        assign rin = rem_s[k];
        assign lin = lo_s[k];
        assign dv  = den_s[k];
        assign qin = quo_s[k];
      end

      assign t    = {rin, lin[QB-1]};
      assign diff = t - {1'b0, dv};
      assign ge   = (t >= {1'b0, dv});

      always_ff @(posedge clk) begin
        if (en) begin
          quo_s[k+1] <= {qin[QB-2:0], ge};
        end
      end

      if (k < QB - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_s[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
            lo_s[k+1]  <= lin << 1;
            den_s[k+1] <= dv;
          end
        end
      end
    end
  endgenerate

  assign quo = quo_s[QB];

endmodule

[rtl/core/euler_mirror_wall_ghost_state_unit.sv]
// Top level of the reflective slip wall ghost state unit for 3D Euler faces.
// Depends on emwgs_pkg, emwgs_sqrt and emwgs_div.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------------
//  input    | in        | in_valid / in_ready   | density, vel_x/y/z, speed, pressure,
//           |           |                       | temperature, normal_x/y/z
//  output   | out       | out_valid / out_ready | ghost_* fields and invalid
//  config   | in        | APB psel/penable      | gamma_ratio at byte address 0
//
// One word can enter every cycle while the pipeline advances and no gamma division runs. A
// word passes through 79 register stages, then the output register takes it from the last
// stage. The depth comes from the bit-per-stage units: a 32-stage root for the normal
// length, a 17-stage divider for the unit normal, and in parallel a 46-stage divider and a
// 31-stage root for the sound speed. After reset and after every gamma write, input is held
// off while gamma/(gamma-1) is worked out by a serial divider.
// The pipeline moves as a whole; it freezes only when its last stage and the output register
// both hold a word that has not been taken, so a waiting result does not block new input.
module euler_mirror_wall_ghost_state_unit
  import emwgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_ready,
  input  q31_t        density,
  input  q32s_t       vel_x,
  input  q32s_t       vel_y,
  input  q32s_t       vel_z,
  input  q31_t        speed,
  input  q31_t        pressure,
  input  q31_t        temperature,
  input  q32s_t       normal_x,
  input  q32s_t       normal_y,
  input  q32s_t       normal_z,

  output logic        out_valid,
  input  logic        out_ready,
  output q31_t        ghost_density,
  output q32s_t       ghost_vel_x,
  output q32s_t       ghost_vel_y,
  output q32s_t       ghost_vel_z,
  output q31_t        ghost_speed,
  output q31_t        ghost_pressure,
  output q31_t        ghost_enthalpy,
  output q31_t        ghost_sound_speed,
  output q31_t        ghost_temperature,
  output logic        invalid
);

  // Stage numbers: a word taken at an edge sits in stage 1 after that edge.
  localparam int S_LEN  = 2 + 32;         // normal length leaves its root unit
  localparam int S_UNIT = S_LEN + 17;     // unit normal magnitudes leave their dividers
  localparam int S_VEL  = S_UNIT + 4;     // reflected velocity is registered
  localparam int S_HQ   = 2 + 31;         // enthalpy pressure term leaves its divider
  localparam int S_H    = S_HQ + 1;       // total enthalpy is registered
  localparam int S_QQ   = 2 + 46;         // gamma p / rho leaves its divider
  localparam int LAST   = S_QQ + 31;      // sound speed root done, last stage

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  // ---------------------------------------------------------------------------------------
  // Configuration port and the gamma/(gamma-1) sequencer.
  // The ratio is a property of the gas, not of the face, so it is divided out once per
  // write by a bit-serial divider and held in gdg. A quotient of 2^31 or more, or a gamma
  // not above one, saturates.
  // ---------------------------------------------------------------------------------------
  logic        cfg_wr;
  logic        cfg_idx;
  logic [18:0] g;
  logic [18:0] gden;
  logic [18:0] grem;
  logic [30:0] glo;
  logic [30:0] gquo;
  q31_t        gdg;
  logic [4:0]  gcnt;
  logic [1:0]  state;
  logic [19:0] gtry;
  logic [19:0] gdiff;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == REG_GAMMA) ? {13'd0, g} : 32'd0;

  assign gden  = g - Q_ONE;
  assign gtry  = {grem, glo[30]};
  assign gdiff = gtry - {1'b0, gden};

  always_ff @(posedge clk) begin
    if (rst) begin
      g     <= GAMMA_RESET;
      state <= ST_LOAD;
      gcnt  <= '0;
    end else if (cfg_wr && cfg_idx == REG_GAMMA) begin
      g     <= pwdata[18:0];
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          if (g <= Q_ONE || 19'(g[18:15]) >= gden) begin
            gdg   <= SAT31;
            state <= ST_IDLE;
          end else begin
            grem  <= 19'(g[18:15]);
            glo   <= {g[14:0], 16'd0};
            gquo  <= '0;
            gcnt  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          grem <= gdiff[19] ? gtry[18:0] : gdiff[18:0];
          glo  <= glo << 1;
          gquo <= {gquo[29:0], ~gdiff[19]};
          if (gcnt == 5'd30) begin
            gdg   <= {gquo[29:0], ~gdiff[19]};
            state <= ST_IDLE;
          end else begin
            gcnt <= gcnt + 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. Valid bits travel with the data; adv moves every stage at once.
  // ---------------------------------------------------------------------------------------
  logic [LAST:1] vld;
  logic          adv;
  logic          acc;

  assign adv      = ~vld[LAST] | ~out_valid | out_ready;
  assign in_ready = adv && (state == ST_IDLE);
  assign acc      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:1], acc};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Delay lines that carry fields to the stage where they are needed.
  // Vectors are packed x in the low word, then y, then z.
  // ---------------------------------------------------------------------------------------
  q31_t          rho_d [1:LAST];
  q31_t          spd_d [1:LAST];
  q31_t          p_d   [1:LAST];
  q31_t          t_d   [1:LAST];
  logic [95:0]   n_d   [1:S_UNIT];
  logic [95:0]   v_d   [1:S_VEL-1];
  logic [61:0]   ss_d  [1:S_HQ];
  logic [95:0]   gv_d  [S_VEL:LAST];
  q31_t          h_d   [S_H:LAST];
  logic [LAST:1] badr_d;
  logic [LAST:1] badn_d;
  logic [S_HQ:2] hsat_d;
  logic [LAST:2] qsat_d;

  // Stage 1 products.
  logic signed [63:0] sqx_c;
  logic signed [63:0] sqy_c;
  logic signed [63:0] sqz_c;
  logic [61:0]        hp_c;
  logic [49:0]        gp_c;
  logic [61:0]        ss_c;
  logic [62:0]        sq [3];
  logic [61:0]        hp;
  logic [49:0]        gp;

  assign sqx_c = normal_x * normal_x;
  assign sqy_c = normal_y * normal_y;
  assign sqz_c = normal_z * normal_z;
  assign hp_c  = gdg * pressure;
  assign gp_c  = g * pressure;
  assign ss_c  = speed * speed;

  // Stage 2 operands for the root and the dividers.
  logic [63:0] sumsq;
  logic [61:0] hnum;
  q31_t        hden;
  logic [49:0] qnum;
  q31_t        qden;
  logic        hsat_c;
  logic        qsat_c;

  assign hsat_c = (hp[61:31] >= rho_d[1]);
  assign qsat_c = (31'(gp[49:46]) >= rho_d[1]);

  // Velocity path beyond the unit normal.
  logic [31:0]        len;
  logic [16:0]        uq    [3];
  logic signed [17:0] us_c  [3];
  logic signed [49:0] pr_c  [3];
  logic signed [17:0] u52   [3];
  logic signed [17:0] u53   [3];
  logic signed [49:0] pr52  [3];
  logic signed [51:0] vsum_c;
  logic signed [35:0] vn53;
  logic signed [53:0] p2_c  [3];
  logic signed [53:0] p2_54 [3];
  logic signed [39:0] diff_c [3];
  logic [31:0]        gv_c  [3];

  // Enthalpy and sound speed path.
  q31_t        hq;
  logic [45:0] qq;
  q31_t        aroot;
  logic [45:0] hsum_c;
  q31_t        h_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: squares and products.
      rho_d[1]  <= density;
      spd_d[1]  <= speed;
      p_d[1]    <= pressure;
      t_d[1]    <= temperature;
      n_d[1]    <= {normal_z, normal_y, normal_x};
      v_d[1]    <= {vel_z, vel_y, vel_x};
      ss_d[1]   <= ss_c;
      badr_d    <= {badr_d[LAST-1:1], density == '0};
      badn_d    <= {badn_d[LAST-1:1],
                    normal_x == '0 && normal_y == '0 && normal_z == '0};
      sq[0]     <= sqx_c[62:0];
      sq[1]     <= sqy_c[62:0];
      sq[2]     <= sqz_c[62:0];
      hp        <= hp_c;
      gp        <= gp_c;

      // Stage 2: squared length and divider operands. A saturated or zero-density
      // quotient is replaced later, so its divider runs on zero.
      sumsq  <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      hsat_d <= {hsat_d[S_HQ-1:2], hsat_c};
      qsat_d <= {qsat_d[LAST-1:2], qsat_c};
      hnum   <= (hsat_c || badr_d[1]) ? '0 : hp;
      hden   <= badr_d[1] ? 31'd1 : rho_d[1];
      qnum   <= (qsat_c || badr_d[1]) ? '0 : gp;
      qden   <= badr_d[1] ? 31'd1 : rho_d[1];

      for (int k = 2; k <= LAST; k++) begin
        rho_d[k] <= rho_d[k-1];
        spd_d[k] <= spd_d[k-1];
        p_d[k]   <= p_d[k-1];
        t_d[k]   <= t_d[k-1];
      end
      for (int k = 2; k <= S_UNIT; k++) begin
        n_d[k] <= n_d[k-1];
      end
      for (int k = 2; k <= S_VEL - 1; k++) begin
        v_d[k] <= v_d[k-1];
      end
      for (int k = 2; k <= S_HQ; k++) begin
        ss_d[k] <= ss_d[k-1];
      end

      // Velocity: v.u, then v - 2 (v.u) u.
      for (int i = 0; i < 3; i++) begin
        u52[i]   <= us_c[i];
        pr52[i]  <= pr_c[i];
        u53[i]   <= u52[i];
        p2_54[i] <= p2_c[i];
      end
      vn53 <= vsum_c[51:16];
      gv_d[S_VEL] <= {gv_c[2], gv_c[1], gv_c[0]};
      for (int k = S_VEL + 1; k <= LAST; k++) begin
        gv_d[k] <= gv_d[k-1];
      end

      // Enthalpy.
      h_d[S_H] <= h_c;
      for (int k = S_H + 1; k <= LAST; k++) begin
        h_d[k] <= h_d[k-1];
      end
    end
  end

  // Length of the face normal.
  emwgs_sqrt #(.W(64)) u_len (
    .clk  (clk),
    .en   (adv),
    .din  (sumsq),
    .root (len)
  );

  // Unit normal magnitudes: |n_i| * 2^16 / L. A zero normal divides zero by one.
  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_unit
      logic [31:0] ncomp;
      logic [31:0] mag;
      logic [47:0] unum;
      logic [31:0] uden;

      assign ncomp = n_d[S_LEN][32*gi +: 32];
      assign mag   = ncomp[31] ? (~ncomp + 32'd1) : ncomp;
      assign unum  = badn_d[S_LEN] ? 48'd0 : {mag, 16'd0};
      assign uden  = badn_d[S_LEN] ? 32'd1 : len;

      emwgs_div #(.NW(48), .DW(32), .QB(17)) u_udiv (
        .clk (clk),
        .en  (adv),
        .num (unum),
        .den (uden),
        .quo (uq[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      us_c[i] = n_d[S_UNIT][32*i+31] ? -$signed({1'b0, uq[i]}) : $signed({1'b0, uq[i]});
      pr_c[i] = $signed(v_d[S_UNIT][32*i +: 32]) * us_c[i];
      p2_c[i] = vn53 * u53[i];
      // Doubling before the shift by 16 is the same as shifting by 15.
      diff_c[i] = $signed(v_d[S_VEL-1][32*i +: 32]) - $signed(p2_54[i][53:15]);
      if (diff_c[i][39:31] == '0 || diff_c[i][39:31] == '1) begin
        gv_c[i] = diff_c[i][31:0];
      end else if (diff_c[i][39]) begin
        gv_c[i] = 32'h8000_0000;
      end else begin
        gv_c[i] = 32'h7FFF_FFFF;
      end
    end
  end

  assign vsum_c = pr52[0] + pr52[1] + pr52[2];

  // Pressure term of the enthalpy: gdg * p / rho.
  emwgs_div #(.NW(62), .DW(31), .QB(31)) u_hdiv (
    .clk (clk),
    .en  (adv),
    .num (hnum),
    .den (hden),
    .quo (hq)
  );

  assign hsum_c = 46'(hq) + 46'(ss_d[S_HQ][61:17]);
  assign h_c    = (hsat_d[S_HQ] || hsum_c > 46'(SAT31)) ? SAT31 : hsum_c[30:0];

  // Sound speed: gamma * p / rho, then the root of that in Q15.16.
  emwgs_div #(.NW(50), .DW(31), .QB(46)) u_qdiv (
    .clk (clk),
    .en  (adv),
    .num (qnum),
    .den (qden),
    .quo (qq)
  );

  emwgs_sqrt #(.W(62)) u_snd (
    .clk  (clk),
    .en   (adv),
    .din  ({qq, 16'd0}),
    .root (aroot)
  );

  // ---------------------------------------------------------------------------------------
  // Output register. It takes the last stage whenever it is empty or being emptied.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && vld[LAST]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[LAST]) begin
      ghost_density     <= rho_d[LAST];
      ghost_vel_x       <= gv_d[LAST][31:0];
      ghost_vel_y       <= gv_d[LAST][63:32];
      ghost_vel_z       <= gv_d[LAST][95:64];
      ghost_speed       <= spd_d[LAST];
      ghost_pressure    <= p_d[LAST];
      ghost_temperature <= t_d[LAST];
      ghost_enthalpy    <= badr_d[LAST] ? '0 : h_d[LAST];
      ghost_sound_speed <= badr_d[LAST] ? '0 : (qsat_d[LAST] ? SAT31 : aroot);
      invalid           <= badr_d[LAST] | badn_d[LAST];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  a_valid_rho: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid |-> ghost_density != '0)
    else $error("valid result with zero density");

  a_zero_rho: assert property (@(posedge clk) disable iff (rst)
    out_valid && ghost_density == '0 |-> invalid && ghost_enthalpy == '0
      && ghost_sound_speed == '0)
    else $error("zero density result not cleared");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[LAST]))
    else $error("output word appeared without a word in the last stage");

endmodule
